FILE: rtl/core/dmne_pkg.sv
// Shared types and constants for the difference MAD noise estimator.
package dmne_pkg;

  // Width of the noise result (Q8) and its saturation value.
  localparam int unsigned NOISE_W = 25;
  localparam logic [NOISE_W-1:0] NOISE_MAX = {NOISE_W{1'b1}};

  // 1 / (sqrt(2) * 0.6745) in Q16, rounded.
  localparam int unsigned SCALE_W = 17;
  localparam logic [SCALE_W-1:0] SCALE_Q16 = 17'd68704;

  // Shift for the Q16 to Q8 rounding step.
  localparam int unsigned RND_SHIFT = 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEL,
    S_MUL,
    S_RND
  } dmne_state_e;

endpackage

FILE: rtl/core/difference_mad_noise_estimator.sv
// Top level of the difference MAD noise estimator: ingest, median select, scale.
//
// Usage:
//   Samples enter on sample_i/last_i, one item per cycle, accepted at a rising
//   edge with start high and busy low. Every sample after the first of a frame
//   writes |sample - previous| into the difference memory (MAX_SAMPLES-1 words).
//   Samples past MAX_SAMPLES are dropped and flag the frame as overflowed.
//   An item with last_i set closes the frame: busy rises and the block selects
//   the element of rank floor(m/2) among the m stored differences, then scales
//   it by 1/(sqrt(2)*0.6745) and rounds to Q8, saturating at 2^25-1.
//   The result shows on noise_q8_o/overflow_o for one cycle with valid_o high;
//   the receiver has no back-pressure. A frame of fewer than two samples
//   gives 0.
// Sequencing:
//   Samples stream at one per cycle while busy is low. After the closing item,
//   the selection does SAMPLE_BITS radix passes over the memory (one read port,
//   registered read data), then one multiply and one rounding step (frames of
//   fewer than two samples skip the passes); valid_o rises and busy falls in
//   that same cycle.
// Reset:
//   Clears frame state and control; memory contents stay undefined and are
//   only read where written in the current frame.
module difference_mad_noise_estimator #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  output logic                          valid_o,
  output logic [dmne_pkg::NOISE_W-1:0]  noise_q8_o,
  output logic                          overflow_o
);
  import dmne_pkg::*;

  localparam int unsigned DW    = SAMPLE_BITS;                 // difference width
  localparam int unsigned DEPTH = MAX_SAMPLES - 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(MAX_SAMPLES + 1);     // holds 0..MAX_SAMPLES
  localparam int unsigned BW    = $clog2(DW);                  // bit index
  localparam int unsigned PW    = DW + SCALE_W;                // product width
  localparam int unsigned RW    = PW + 1 - RND_SHIFT;          // rounded width
  localparam int unsigned EW    = (RW > NOISE_W + 1) ? RW : NOISE_W + 1;

  localparam logic [CW-1:0] MaxCnt = CW'(MAX_SAMPLES);

  // ---------------------------------------------------------------- state
  dmne_state_e state_q, state_d;

  // Frame ingest state.
  logic signed [DW-1:0] prev_q;
  logic [CW-1:0]        count_q;
  logic                 ovf_q;

  // Selection state.
  logic [CW-1:0] m_q;       // number of differences in the frame
  logic [CW-1:0] k_q;       // remaining rank inside the current prefix bucket
  logic [CW-1:0] issue_q;   // next read index
  logic [CW-1:0] cnt_q;     // matches with current bit zero
  logic          rd_vld_q;
  logic [BW-1:0] bit_q;
  logic [DW-1:0] pref_q;
  logic [DW-1:0] med_q;
  logic [PW-1:0] prod_q;
  logic          ovf_res_q;

  // Output registers.
  logic               valid_q;
  logic [NOISE_W-1:0] noise_q;

  // Difference memory.
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          rd_en;

  // ---------------------------------------------------------------- ingest
  logic                 accept;
  logic                 take;       // sample enters the difference memory
  logic [CW-1:0]        count_nx;
  logic signed [DW:0]   diff;
  logic [DW-1:0]        absdiff;
  logic                 ovf_nx;
  logic [CW-1:0]        m_nx;

  assign accept = start && !busy;

  always_comb begin
    diff    = {sample_i[DW-1], sample_i} - {prev_q[DW-1], prev_q};
    absdiff = diff[DW] ? DW'(-diff) : diff[DW-1:0];
    take    = (count_q != '0) && (count_q < MaxCnt);
    ovf_nx  = ovf_q || (count_q >= MaxCnt);
    if (count_q == '0) begin
      count_nx = CW'(1);
    end else if (take) begin
      count_nx = count_q + 1'b1;
    end else begin
      count_nx = count_q;
    end
    m_nx    = count_nx - 1'b1;
    wr_en   = accept && take;
    wr_addr = AW'(count_q - 1'b1);
    wr_data = absdiff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      if (count_q == '0 || take) begin
        prev_q <= sample_i;
      end
      if (last_i) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        count_q <= count_nx;
        ovf_q   <= ovf_nx;
      end
    end
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[issue_q[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------- select
  // Radix select: per bit (MSB first) count entries that share the decided
  // prefix and have a zero here; the rank picks the bucket.
  logic [DW-1:0] mask_above;
  logic          match;
  logic          pass_end;
  logic          go_low;
  logic [DW-1:0] pref_set;

  always_comb begin
    mask_above = {DW{1'b1}} << ({1'b0, bit_q} + 1'b1);
    match      = (((rdata_q ^ pref_q) & mask_above) == '0) && !rdata_q[bit_q];
    rd_en      = (state_q == S_SEL) && (issue_q < m_q);
    pass_end   = (state_q == S_SEL) && (issue_q == m_q) && !rd_vld_q;
    go_low     = k_q < cnt_q;
    pref_set   = pref_q;
    pref_set[bit_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept && last_i) begin
          m_q       <= m_nx;
          k_q       <= m_nx >> 1;
          issue_q   <= '0;
          cnt_q     <= '0;
          bit_q     <= BW'(DW - 1);
          pref_q    <= '0;
          med_q     <= '0;
          ovf_res_q <= ovf_nx;
        end
      end
      S_SEL: begin
        if (rd_en) begin
          issue_q <= issue_q + 1'b1;
        end
        if (rd_vld_q && match) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (pass_end) begin
          issue_q <= '0;
          cnt_q   <= '0;
          bit_q   <= bit_q - 1'b1;
          if (go_low) begin
            med_q <= pref_q;
          end else begin
            pref_q <= pref_set;
            k_q    <= k_q - cnt_q;
            med_q  <= pref_set;
          end
        end
      end
      S_MUL: begin
        prod_q <= PW'(med_q) * PW'(SCALE_Q16);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- round
  logic [RW-1:0] rnd;
  logic [EW-1:0] rnd_ext;
  logic          sat;

  always_comb begin
    rnd     = RW'(({1'b0, prod_q} + (PW+1)'(1 << (RND_SHIFT - 1))) >> RND_SHIFT);
    rnd_ext = EW'(rnd);
    sat     = |rnd_ext[EW-1:NOISE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (state_q == S_RND);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RND) begin
      noise_q <= sat ? NOISE_MAX : rnd_ext[NOISE_W-1:0];
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && last_i) begin
          state_d = (count_nx < CW'(2)) ? S_MUL : S_SEL;
        end
      end
      S_SEL: begin
        if (pass_end && bit_q == '0) begin
          state_d = S_MUL;
        end
      end
      S_MUL:   state_d = S_RND;
      S_RND:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_q != S_IDLE);
  end

  assign valid_o    = valid_q;
  assign noise_q8_o = noise_q;
  assign overflow_o = ovf_res_q;

  // ---------------------------------------------------------------- checks
  a_valid_after_rnd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == S_RND))
    else $error("result strobe without rounding step");

  a_valid_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  a_rank_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEL) |-> (k_q < m_q))
    else $error("selection rank out of range");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("sample count past limit");

endmodule

FILE: dv/testbench.sv
// Testbench for the difference MAD noise estimator: framed samples checked against a local predictor.
`timescale 1ns / 1ps

module testbench;
  import dmne_pkg::*;

  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned SAMPLE_BITS = 16;

  // 1 / (sqrt(2) * 0.6745) in Q16; the product is rounded half up into Q8.
  localparam longint unsigned SCALE_Q16_TB = 68704;
  localparam longint unsigned Q8_HALF      = 128;
  localparam longint unsigned NOISE_SAT    = (64'd1 << NOISE_W) - 1;

  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = ~S_MIN;

  // Random items on top of the directed ones, at least 1150 in all.
  localparam int unsigned RANDOM_ITEMS  = 1130;
  localparam int unsigned SETTLE_CYCLES = 100;
  // Timeout bound, with a wide margin over the slowest legal run (one
  // full-size frame, long gaps on every item).
  localparam int unsigned LIMIT_CYCLES  = 1000000;

  // Content shape of one random frame.
  typedef enum logic [1:0] {
    WIDE,    // uniform over the whole sample range
    JITTER,  // small noise around a random base
    FLAT,    // constant with rare spikes, many equal differences
    RAIL     // only the two extremes
  } frame_style_e;

  // One pending input item; drain holds it back until no result is outstanding.
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    bit                            drain;
  } sample_item_t;

  typedef struct {
    logic [NOISE_W-1:0] noise;
    logic               overflow;
  } noise_result_t;

  logic                          clk_i;
  logic                          rst_ni   = 1'b0;
  logic                          start    = 1'b0;
  logic                          busy;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic                          last_i   = 1'b0;
  logic                          valid_o;
  logic [NOISE_W-1:0]            noise_q8_o;
  logic                          overflow_o;

  sample_item_t  pending_q [$];
  noise_result_t noise_exp_q [$];
  int unsigned   err_cnt = 0;

  // Predictor frame state.
  logic signed [SAMPLE_BITS-1:0] pred_prev  = '0;
  int unsigned                   pred_count = 0;
  int unsigned                   pred_diff [MAX_SAMPLES-1];
  bit                            pred_ovf   = 1'b0;

  // Driver pacing.
  int unsigned gap_left  = 0;
  int unsigned calm_left = 0;

  // From the closing item until valid_o, busy is held high; samples otherwise
  // stream one per cycle.
  difference_mad_noise_estimator #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .sample_i   (sample_i),
    .last_i     (last_i),
    .valid_o    (valid_o),
    .noise_q8_o (noise_q8_o),
    .overflow_o (overflow_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Element of rank floor(m/2) among the first m stored differences: the
  // value whose count of smaller entries is at most the rank and whose count
  // of smaller-or-equal entries passes it.
  function automatic int unsigned upper_median(input int unsigned m);
    int unsigned rank;
    int unsigned below;
    int unsigned equal;
    rank = m / 2;
    for (int unsigned i = 0; i < m; i++) begin
      below = 0;
      equal = 0;
      for (int unsigned j = 0; j < m; j++) begin
        if (pred_diff[j] < pred_diff[i]) begin
          below++;
        end else if (pred_diff[j] == pred_diff[i]) begin
          equal++;
        end
      end
      if (below <= rank && rank < below + equal) begin
        return pred_diff[i];
      end
    end
    return 0;
  endfunction

  // Fold one accepted sample into the frame; a closing sample queues the
  // expected estimate and clears the frame.
  task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic fin);
    logic signed [SAMPLE_BITS:0] d;
    longint unsigned             scaled;
    noise_result_t               r;
    if (pred_count == 0) begin
      pred_prev  = s;
      pred_count = 1;
    end else if (pred_count < MAX_SAMPLES) begin
      d = s - pred_prev;
      pred_diff[pred_count-1] = (d < 0) ? -d : d;
      pred_prev  = s;
      pred_count++;
    end else begin
      // frame full: sample dropped, previous sample kept
      pred_ovf = 1'b1;
    end
    if (fin) begin
      r.noise = '0;
      if (pred_count >= 2) begin
        scaled = upper_median(pred_count - 1);
        scaled = (scaled * SCALE_Q16_TB + Q8_HALF) >> 8;
        r.noise = (scaled > NOISE_SAT) ? NOISE_SAT[NOISE_W-1:0] : NOISE_W'(scaled);
      end
      r.overflow = pred_ovf;
      noise_exp_q.push_back(r);
      pred_count = 0;
      pred_ovf   = 1'b0;
    end
  endtask

  task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic fin,
                              input bit drain);
    sample_item_t it;
    it.sample = s;
    it.last   = fin;
    it.drain  = drain;
    pending_q.push_back(it);
  endtask

  task automatic queue_frame(input int unsigned len, input bit drain);
    frame_style_e                  style;
    logic signed [SAMPLE_BITS-1:0] base;
    logic signed [SAMPLE_BITS-1:0] s;
    int unsigned                   amp;
    style = frame_style_e'($urandom_range(0, 3));
    base  = SAMPLE_BITS'($urandom());
    amp   = 1 << $urandom_range(0, 12);
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        WIDE: begin
          s = SAMPLE_BITS'($urandom());
        end
        JITTER: begin
          s = base + SAMPLE_BITS'($urandom_range(0, 2 * amp)) - SAMPLE_BITS'(amp);
        end
        FLAT: begin
          s = ($urandom_range(0, 7) == 0) ? SAMPLE_BITS'($urandom()) : base;
        end
        default: begin
          s = $urandom_range(0, 1) ? S_MAX : S_MIN;
        end
      endcase
      queue_sample(s, i == len - 1, drain && i == 0);
    end
  endtask

  // Driver: an item is taken at an edge with start high and busy low; the
  // predictor sees it at that same edge. A new item goes out only once the
  // previous one is taken, after its random gap.
  always @(posedge clk_i) begin
    sample_item_t it;
    bit           take;
    int unsigned  r;
    if (!rst_ni) begin
      start    <= 1'b0;
      sample_i <= '0;
      last_i   <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        absorb_sample(sample_i, last_i);
      end
      if (take || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() == 0) begin
          start <= 1'b0;
        end else if (pending_q[0].drain && (noise_exp_q.size() != 0 || valid_o)) begin
          // hold off until every outstanding estimate has come back
          start <= 1'b0;
        end else begin
          it = pending_q.pop_front();
          start    <= 1'b1;
          sample_i <= it.sample;
          last_i   <= it.last;
          // gap after this item: mostly none, some short, a few long, and
          // now and then a long back-to-back stretch
          if (calm_left > 0) begin
            calm_left--;
            gap_left = 0;
          end else begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
              calm_left = $urandom_range(30, 150);
              gap_left  = 0;
            end else if (r < 62) begin
              gap_left = 0;
            end else if (r < 94) begin
              gap_left = $urandom_range(1, 3);
            end else begin
              gap_left = $urandom_range(8, 40);
            end
          end
        end
      end
    end
  end

  // Monitor: results last one cycle and cannot be held off.
  always @(posedge clk_i) begin
    noise_result_t want;
    if (rst_ni && valid_o !== 1'b0) begin
      if (noise_exp_q.size() == 0) begin
        $display("%0t: result with none expected: noise_q8 %0d overflow %0b",
                 $time, noise_q8_o, overflow_o);
        err_cnt++;
      end else begin
        want = noise_exp_q.pop_front();
        if (noise_q8_o !== want.noise) begin
          $display("%0t: noise_q8 expected %0d actual %0d", $time, want.noise, noise_q8_o);
          err_cnt++;
        end
        if (overflow_o !== want.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time, want.overflow, overflow_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned queued;
    int unsigned frames;
    int unsigned len;
    int unsigned r;
    int unsigned over_frame;

    // Short frames: one sample gives 0, at both extremes.
    queue_sample(S_MIN, 1'b1, 1'b0);
    queue_sample(S_MAX, 1'b1, 1'b0);
    // Largest difference, both directions.
    queue_sample(S_MIN, 1'b0, 1'b0);
    queue_sample(S_MAX, 1'b1, 1'b0);
    queue_sample(S_MAX, 1'b0, 1'b0);
    queue_sample(S_MIN, 1'b1, 1'b0);
    // Zero difference.
    queue_sample(16'sd0, 1'b0, 1'b0);
    queue_sample(16'sd0, 1'b1, 1'b0);
    // Even count: differences 1, 2, 7, 9 pick the upper median 7.
    queue_sample(16'sd100, 1'b0, 1'b0);
    queue_sample(16'sd101, 1'b0, 1'b0);
    queue_sample(16'sd99, 1'b0, 1'b0);
    queue_sample(16'sd106, 1'b0, 1'b0);
    queue_sample(16'sd97, 1'b1, 1'b0);
    // Odd count across zero: differences 5, 3, 8 give 5.
    queue_sample(-16'sd5, 1'b0, 1'b0);
    queue_sample(16'sd0, 1'b0, 1'b0);
    queue_sample(-16'sd3, 1'b0, 1'b0);
    queue_sample(16'sd5, 1'b1, 1'b0);
    // Single sample sent only after everything has drained.
    queue_sample(-16'sd1, 1'b1, 1'b1);
    // Difference of one: rounding of the smallest nonzero estimate.
    queue_sample(16'sd7, 1'b0, 1'b0);
    queue_sample(16'sd6, 1'b1, 1'b0);

    // Random frames, mostly small; one frame among them fills the difference
    // memory to its last entry and overruns it, dropping the closing sample
    // and sometimes a few before it.
    over_frame = $urandom_range(3, 10);
    queued = 0;
    frames = 0;
    while (queued < RANDOM_ITEMS) begin
      if (frames == over_frame) begin
        len = MAX_SAMPLES + 1 + $urandom_range(0, 8);
        queue_frame(len, 1'b1);
        queued += len;
      end
      r = $urandom_range(0, 99);
      if (r < 12) begin
        len = 1;
      end else if (r < 70) begin
        len = $urandom_range(2, 12);
      end else begin
        len = $urandom_range(13, 64);
      end
      queue_frame(len, frames == 0 || $urandom_range(0, 15) == 0);
      queued += len;
      frames++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampled on the falling edge, away from the driver and monitor updates.
    do begin
      @(negedge clk_i);
    end while (pending_q.size() != 0 || start || noise_exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(2 * LIMIT_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/dmne_pkg.sv
rtl/core/difference_mad_noise_estimator.sv
dv/testbench.sv
